// ===== src/hxl_pkg.sv =====
// shared types, codes and character helpers for the hex text memory loader
package hxl_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int COUNT_BITS    = 32;
    localparam logic [31:0] MEM_LEN_RESET = 32'd65536;

    // result kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_NOCOLON = 2'd1;
    localparam logic [1:0] KIND_RANGE   = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_IGNORE    = 4'd1,
        PH_ZERO      = 4'd2,
        PH_ADDR      = 4'd3,
        PH_PRECOLON  = 4'd4,
        PH_POSTCOLON = 4'd5,
        PH_HIGH      = 4'd6,
        PH_LOW       = 4'd7,
        PH_HALT      = 4'd8
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic [31:0] byte_total;
    } out_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        priority if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            v = c - CH_ZERO;
            return {1'b1, v[3:0]};
        end
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
        begin
            v = c - CH_UP_A + 8'd10;
            return {1'b1, v[3:0]};
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            v = c - CH_LO_A + 8'd10;
            return {1'b1, v[3:0]};
        end
        else
        begin
            return 5'd0;
        end
    endfunction

endpackage

// ===== src/hxl_in_stage.sv =====
// input register holding one character transfer until the parser takes it
module hxl_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    output logic          ready,
    input  hxl_pkg::in_t  item,
    input  logic          take,
    output logic          hold_valid,
    output hxl_pkg::in_t  hold_item
);

    logic         valid_reg;
    hxl_pkg::in_t item_reg;

    assign ready      = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== src/hxl_parser.sv =====
// line parser state, mem_len register and the per-character step logic
module hxl_parser #(
    parameter int ADDR_BITS = hxl_pkg::ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  hxl_pkg::in_t  item,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data,
    output logic          res_valid,
    output hxl_pkg::out_t res
);

    localparam int CMP_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    hxl_pkg::phase_t                phase_reg, phase_next;
    logic [ADDR_BITS-1:0]           addr_reg, addr_next;
    logic [3:0]                     high_reg, high_next;
    logic [hxl_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [31:0]                    mem_len_reg;

    logic [7:0]       c;
    logic [4:0]       hd;
    logic             is_hex;
    logic             blank_no_nl;
    logic [CMP_W-1:0] addr_wide;
    logic [CMP_W-1:0] len_wide;

    assign c           = item.char_in;
    assign hd          = hxl_pkg::hex_digit(c);
    assign is_hex      = hd[4];
    assign blank_no_nl = hxl_pkg::is_blank(c) && (c != hxl_pkg::CH_NEWLINE);
    assign addr_wide   = CMP_W'(addr_reg);
    assign len_wide    = CMP_W'(mem_len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        high_next  = high_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (phase_reg == hxl_pkg::PH_HALT)
        begin
            res_valid = 1'b0;
        end
        else if (item.command == hxl_pkg::CMD_END)
        begin
            phase_next = hxl_pkg::PH_HALT;
            res_valid  = 1'b1;
            if ((phase_reg == hxl_pkg::PH_ADDR) || (phase_reg == hxl_pkg::PH_PRECOLON))
            begin
                res.kind = hxl_pkg::KIND_NOCOLON;
            end
            else
            begin
                res.kind       = hxl_pkg::KIND_DONE;
                res.byte_total = count_reg;
            end
        end
        else
        begin
            unique case (phase_reg)
                hxl_pkg::PH_START:
                begin
                    if (c == hxl_pkg::CH_ZERO)
                        phase_next = hxl_pkg::PH_ZERO;
                    else if (!hxl_pkg::is_blank(c))
                        phase_next = hxl_pkg::PH_IGNORE;
                end
                hxl_pkg::PH_IGNORE:
                begin
                    if (c == hxl_pkg::CH_NEWLINE)
                        phase_next = hxl_pkg::PH_START;
                end
                hxl_pkg::PH_ZERO:
                begin
                    if ((c == hxl_pkg::CH_LO_X) || (c == hxl_pkg::CH_UP_X))
                    begin
                        addr_next  = '0;
                        phase_next = hxl_pkg::PH_ADDR;
                    end
                    else if (c == hxl_pkg::CH_NEWLINE)
                        phase_next = hxl_pkg::PH_START;
                    else
                        phase_next = hxl_pkg::PH_IGNORE;
                end
                hxl_pkg::PH_ADDR, hxl_pkg::PH_PRECOLON:
                begin
                    if ((phase_reg == hxl_pkg::PH_ADDR) && is_hex)
                        addr_next = {addr_reg[ADDR_BITS-5:0], hd[3:0]};
                    else if (c == hxl_pkg::CH_COLON)
                        phase_next = hxl_pkg::PH_POSTCOLON;
                    else if (blank_no_nl)
                        phase_next = hxl_pkg::PH_PRECOLON;
                    else
                    begin
                        phase_next = hxl_pkg::PH_HALT;
                        res_valid  = 1'b1;
                        res.kind   = hxl_pkg::KIND_NOCOLON;
                    end
                end
                hxl_pkg::PH_POSTCOLON, hxl_pkg::PH_HIGH:
                begin
                    if (is_hex)
                    begin
                        high_next  = hd[3:0];
                        phase_next = hxl_pkg::PH_LOW;
                    end
                    else if ((phase_reg == hxl_pkg::PH_POSTCOLON) && blank_no_nl)
                        phase_next = phase_reg;
                    else if (c == hxl_pkg::CH_NEWLINE)
                        phase_next = hxl_pkg::PH_START;
                    else
                        phase_next = hxl_pkg::PH_IGNORE;
                end
                hxl_pkg::PH_LOW:
                begin
                    if (is_hex)
                    begin
                        res_valid = 1'b1;
                        if (addr_wide >= len_wide)
                        begin
                            phase_next = hxl_pkg::PH_HALT;
                            res.kind   = hxl_pkg::KIND_RANGE;
                        end
                        else
                        begin
                            addr_next         = addr_reg + 1'b1;
                            count_next        = count_reg + 1'b1;
                            phase_next        = hxl_pkg::PH_HIGH;
                            res.kind          = hxl_pkg::KIND_WRITE;
                            res.write_address = addr_wide[31:0];
                            res.write_data    = {high_reg, hd[3:0]};
                        end
                    end
                    else if (c == hxl_pkg::CH_NEWLINE)
                        phase_next = hxl_pkg::PH_START;
                    else
                        phase_next = hxl_pkg::PH_IGNORE;
                end
                default:
                begin
                    phase_next = hxl_pkg::PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hxl_pkg::PH_START;
            addr_reg    <= '0;
            high_reg    <= 4'd0;
            count_reg   <= '0;
            mem_len_reg <= hxl_pkg::MEM_LEN_RESET;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                addr_reg  <= addr_next;
                high_reg  <= high_next;
                count_reg <= count_next;
            end
            if (cfg_wr_en)
            begin
                mem_len_reg <= cfg_wr_data;
            end
        end
    end

    // once halted the parser never leaves halt until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hxl_pkg::PH_HALT |=> phase_reg == hxl_pkg::PH_HALT)
        else $error("parser left halt");

    // a byte write bumps the count by exactly one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind == hxl_pkg::KIND_WRITE
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("byte count did not advance on write");

    // errors and done always stop the parser
    a_stop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind != hxl_pkg::KIND_WRITE
        |=> phase_reg == hxl_pkg::PH_HALT)
        else $error("parser kept running after error or done");

    // a result never comes out of the halt state
    a_no_result_halted: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hxl_pkg::PH_HALT |-> !res_valid)
        else $error("result while halted");

endmodule

// ===== src/hxl_out_stage.sv =====
// result register between the parser and the result channel
module hxl_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          load_valid,
    input  hxl_pkg::out_t load_item,
    output logic          can_load,
    output logic          valid,
    input  logic          ready,
    output hxl_pkg::out_t item
);

    logic          valid_reg;
    hxl_pkg::out_t item_reg;

    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= load_valid;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ===== src/hex_text_memory_loader_core.sv =====
// top level of the hex text memory loader: input register, parser, result register
// a result passes from the input register through the parser into the result register
// throughput: one character per cycle while no result waits untaken, set by the single parser step per item
// a full result register that is not taken stalls the input register
// reset (rst_n low, async) empties both registers, sets mem_len to 65536 and
// returns the parser to line start with address and byte count at zero
module hex_text_memory_loader_core #(
    parameter int ADDR_BITS = hxl_pkg::ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          char_valid,
    output logic          char_ready,
    input  hxl_pkg::in_t  char_item,
    output logic          res_valid,
    input  logic          res_ready,
    output hxl_pkg::out_t res_item,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data
);

    logic          hold_valid;
    hxl_pkg::in_t  hold_item;
    logic          can_load;
    logic          step;
    logic          step_res_valid;
    hxl_pkg::out_t step_res;

    assign step = hold_valid && can_load;

    hxl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (char_valid),
        .ready      (char_ready),
        .item       (char_item),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    hxl_parser #(
        .ADDR_BITS (ADDR_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (hold_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (step_res_valid),
        .res         (step_res)
    );

    hxl_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (step_res_valid),
        .load_item  (step_res),
        .can_load   (can_load),
        .valid      (res_valid),
        .ready      (res_ready),
        .item       (res_item)
    );

    // a held character waits only behind an untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid && !step |-> res_valid && !res_ready)
        else $error("input stalled without a blocked result");

    // a character transfer lands in the input register
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready |=> hold_valid)
        else $error("accepted character lost");

endmodule
